// File: hdl/jsc_pkg.sv
// jump sequence controller package: phase codes, register indexes, widths and constants
// no dependencies; used by every module of the jump sequence controller
package jsc_pkg;

    localparam int POS_BITS_DEF      = 12;
    localparam int LANDING_ACCEL_DEF = 1300;

    localparam int LOOP_W  = 8;
    localparam int ACCEL_W = 16;
    localparam int LIMIT_W = 10;
    localparam int TIMER_W = 11;
    localparam int SPEED_W = 9;
    localparam int MACC_W  = 8;
    localparam int PHASE_W = 3;
    localparam int INDEX_W = 3;

    localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};

    localparam int CROUCH_OFS     = 40;
    localparam int PUSH_LEFT_OFS  = 20;
    localparam int PUSH_RIGHT_OFS = 40;

    localparam logic [SPEED_W-1:0] PREP_SPEED = 9'd450;
    localparam logic [MACC_W-1:0]  PREP_ACCEL = 8'd250;

    localparam logic [LIMIT_W-1:0] PUSH_TIME_RST   = 10'd200;
    localparam logic [LIMIT_W-1:0] FLY_TIME_RST    = 10'd100;
    localparam logic [LIMIT_W-1:0] LANDING_TO_RST  = 10'd700;
    localparam logic [LIMIT_W-1:0] SETTLE_TIME_RST = 10'd50;

    localparam int LEFT_MIN_RST  = 1024;
    localparam int LEFT_MAX_RST  = 3072;
    localparam int RIGHT_MIN_RST = 3072;
    localparam int RIGHT_MAX_RST = 1024;

    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE    = 3'd0,
        PH_PREPARE = 3'd1,
        PH_PUSH    = 3'd2,
        PH_FLY     = 3'd3,
        PH_LANDING = 3'd4,
        PH_LANDED  = 3'd5
    } phase_t;

    typedef enum logic [INDEX_W-1:0] {
        REG_LEFT_MIN    = 3'd0,
        REG_LEFT_MAX    = 3'd1,
        REG_RIGHT_MIN   = 3'd2,
        REG_RIGHT_MAX   = 3'd3,
        REG_PUSH_TIME   = 3'd4,
        REG_FLY_TIME    = 3'd5,
        REG_LANDING_TO  = 3'd6,
        REG_SETTLE_TIME = 3'd7
    } reg_index_t;

    // timer limits as one bundle between the register file and the sequencer
    typedef struct packed {
        logic [LIMIT_W-1:0] push_time;
        logic [LIMIT_W-1:0] fly_time;
        logic [LIMIT_W-1:0] landing_timeout;
        logic [LIMIT_W-1:0] settle_time;
    } limits_t;

endpackage

// File: hdl/jsc_cfg_regs.sv
// configuration register file of the jump sequence controller
// depends on jsc_pkg
module jsc_cfg_regs #(
    parameter int POS_BITS = jsc_pkg::POS_BITS_DEF,
    parameter int CFG_W    = (POS_BITS > jsc_pkg::LIMIT_W) ? POS_BITS : jsc_pkg::LIMIT_W
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [jsc_pkg::INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]            cfg_wdata,
    output logic [POS_BITS-1:0]         left_min_pos,
    output logic [POS_BITS-1:0]         left_max_pos,
    output logic [POS_BITS-1:0]         right_min_pos,
    output logic [POS_BITS-1:0]         right_max_pos,
    output jsc_pkg::limits_t            limits
);
    import jsc_pkg::*;

    logic [POS_BITS-1:0] left_min_reg, left_max_reg, right_min_reg, right_max_reg;
    limits_t             limits_reg;
    logic [POS_BITS-1:0] wdata_pos;
    logic [LIMIT_W-1:0]  wdata_lim;

    assign wdata_pos = cfg_wdata[POS_BITS-1:0];
    assign wdata_lim = cfg_wdata[LIMIT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_min_reg               <= POS_BITS'(LEFT_MIN_RST);
            left_max_reg               <= POS_BITS'(LEFT_MAX_RST);
            right_min_reg              <= POS_BITS'(RIGHT_MIN_RST);
            right_max_reg              <= POS_BITS'(RIGHT_MAX_RST);
            limits_reg.push_time       <= PUSH_TIME_RST;
            limits_reg.fly_time        <= FLY_TIME_RST;
            limits_reg.landing_timeout <= LANDING_TO_RST;
            limits_reg.settle_time     <= SETTLE_TIME_RST;
        end
        else if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_LEFT_MIN:    left_min_reg               <= wdata_pos;
                REG_LEFT_MAX:    left_max_reg               <= wdata_pos;
                REG_RIGHT_MIN:   right_min_reg              <= wdata_pos;
                REG_RIGHT_MAX:   right_max_reg              <= wdata_pos;
                REG_PUSH_TIME:   limits_reg.push_time       <= wdata_lim;
                REG_FLY_TIME:    limits_reg.fly_time        <= wdata_lim;
                REG_LANDING_TO:  limits_reg.landing_timeout <= wdata_lim;
                REG_SETTLE_TIME: limits_reg.settle_time     <= wdata_lim;
                default:         ;
            endcase
        end
    end

    assign left_min_pos  = left_min_reg;
    assign left_max_pos  = left_max_reg;
    assign right_min_pos = right_min_reg;
    assign right_max_pos = right_max_reg;
    assign limits        = limits_reg;

endmodule

// File: hdl/jsc_sequencer.sv
// phase sequencer: phase and timer registers plus the per-tick next-state and command logic
// depends on jsc_pkg
module jsc_sequencer #(
    parameter int POS_BITS      = jsc_pkg::POS_BITS_DEF,
    parameter int LANDING_ACCEL = jsc_pkg::LANDING_ACCEL_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic [jsc_pkg::LOOP_W-1:0]  loop_time,
    input  logic                        jump_request,
    input  logic signed [jsc_pkg::ACCEL_W-1:0] accel_z,
    input  logic [POS_BITS-1:0]         left_min_pos,
    input  logic [POS_BITS-1:0]         left_max_pos,
    input  logic [POS_BITS-1:0]         right_min_pos,
    input  logic [POS_BITS-1:0]         right_max_pos,
    input  jsc_pkg::limits_t            limits,
    output logic                        servo_write,
    output logic [POS_BITS-1:0]         left_position,
    output logic [POS_BITS-1:0]         right_position,
    output logic [jsc_pkg::SPEED_W-1:0] move_speed,
    output logic [jsc_pkg::MACC_W-1:0]  move_accel,
    output logic [jsc_pkg::PHASE_W-1:0] phase,
    output logic                        jump_active
);
    import jsc_pkg::*;

    localparam int EXT_W  = POS_BITS + 2;
    localparam int AMAG_W = ACCEL_W + 1;
    localparam logic signed [EXT_W-1:0] POS_MAX_EXT = EXT_W'((1 << POS_BITS) - 1);

    phase_t              phase_reg, phase_next;
    logic [TIMER_W-1:0]  timer_reg, timer_next;

    logic [TIMER_W:0]    sum_raw;
    logic [TIMER_W-1:0]  sum_sat;
    logic [LIMIT_W-1:0]  limit_sel;
    logic                timer_done;
    logic signed [AMAG_W-1:0] accel_ext;
    logic [AMAG_W-1:0]   accel_mag;
    logic                accel_spike;

    logic signed [EXT_W-1:0] crouch_left, crouch_right, push_left, push_right;

    function automatic logic [POS_BITS-1:0] clamp_pos(input logic signed [EXT_W-1:0] v);
        logic [POS_BITS-1:0] r;
        if (v < 0)
            r = '0;
        else if (v > POS_MAX_EXT)
            r = POS_MAX_EXT[POS_BITS-1:0];
        else
            r = v[POS_BITS-1:0];
        return r;
    endfunction

    // timer sum saturates at the top of the timer range
    assign sum_raw = {1'b0, timer_reg} + {{(TIMER_W + 1 - LOOP_W){1'b0}}, loop_time};
    assign sum_sat = sum_raw[TIMER_W] ? TIMER_MAX : sum_raw[TIMER_W-1:0];

    always_comb
    begin
        case (phase_reg)
            PH_PUSH:    limit_sel = limits.push_time;
            PH_FLY:     limit_sel = limits.fly_time;
            PH_LANDING: limit_sel = limits.landing_timeout;
            default:    limit_sel = limits.settle_time;
        endcase
    end

    assign timer_done = sum_sat >= {{(TIMER_W - LIMIT_W){1'b0}}, limit_sel};

    assign accel_ext   = AMAG_W'(accel_z);
    assign accel_mag   = accel_ext[AMAG_W-1] ? AMAG_W'(-accel_ext) : AMAG_W'(accel_ext);
    assign accel_spike = accel_mag >= AMAG_W'(LANDING_ACCEL);

    assign crouch_left  = $signed({2'b00, left_min_pos})  - EXT_W'(CROUCH_OFS);
    assign crouch_right = $signed({2'b00, right_min_pos}) + EXT_W'(CROUCH_OFS);
    assign push_left    = $signed({2'b00, left_max_pos})  + EXT_W'(PUSH_LEFT_OFS);
    assign push_right   = $signed({2'b00, right_max_pos}) - EXT_W'(PUSH_RIGHT_OFS);

    // next phase and timer
    always_comb
    begin
        phase_next = phase_reg;
        timer_next = timer_reg;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (jump_request)
                begin
                    timer_next = '0;
                    phase_next = PH_PREPARE;
                end
            end
            PH_PREPARE:
                phase_next = PH_PUSH;
            PH_PUSH:
            begin
                timer_next = timer_done ? '0 : sum_sat;
                if (timer_done)
                    phase_next = PH_FLY;
            end
            PH_FLY:
            begin
                timer_next = timer_done ? '0 : sum_sat;
                if (timer_done)
                    phase_next = PH_LANDING;
            end
            PH_LANDING:
            begin
                // an acceleration spike ends landing but keeps the timer
                timer_next = timer_done ? '0 : sum_sat;
                if (timer_done || accel_spike)
                    phase_next = PH_LANDED;
            end
            PH_LANDED:
            begin
                timer_next = timer_done ? '0 : sum_sat;
                if (timer_done)
                    phase_next = PH_IDLE;
            end
            default:
                phase_next = PH_IDLE;
        endcase
    end

    // servo commands for this tick
    always_comb
    begin
        servo_write    = 1'b0;
        left_position  = '0;
        right_position = '0;
        move_speed     = '0;
        move_accel     = '0;
        unique case (phase_reg)
            PH_PREPARE:
            begin
                servo_write    = 1'b1;
                left_position  = clamp_pos(crouch_left);
                right_position = clamp_pos(crouch_right);
                move_speed     = PREP_SPEED;
                move_accel     = PREP_ACCEL;
            end
            PH_PUSH:
            begin
                if (timer_done)
                begin
                    servo_write    = 1'b1;
                    left_position  = clamp_pos(push_left);
                    right_position = clamp_pos(push_right);
                end
            end
            PH_FLY:
            begin
                if (timer_done)
                begin
                    servo_write    = 1'b1;
                    left_position  = left_min_pos;
                    right_position = right_min_pos;
                end
            end
            default:
            begin
                servo_write = 1'b0;
            end
        endcase
    end

    assign phase       = phase_next;
    assign jump_active = phase_next != PH_IDLE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            timer_reg <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            timer_reg <= timer_next;
        end
    end

endmodule

// File: hdl/jump_sequence_controller.sv
// jump sequence controller top level: configuration registers, input register, sequencer and result register
// depends on jsc_pkg, jsc_cfg_regs and jsc_sequencer
//
// Each input word is one control tick. It is taken into an input register, the
// sequencer works out the next phase, timer and servo commands in one pass of
// logic, and the result word lands in an output register, so a tick can be
// accepted every clock cycle while the output register is free or emptying;
// its result moves into the output register once that one is free or emptying.
// The input register keeps taking words while a result waits at the output, as
// long as it is free or moving on. The user must write registers through the
// plain write port only while no tick is in flight; the block does not enforce
// this. An unused phase code sends the sequencer back to idle, no servo command.
module jump_sequence_controller #(
    parameter int POS_BITS      = jsc_pkg::POS_BITS_DEF,
    parameter int LANDING_ACCEL = jsc_pkg::LANDING_ACCEL_DEF,
    parameter int CFG_W         = (POS_BITS > jsc_pkg::LIMIT_W) ? POS_BITS : jsc_pkg::LIMIT_W
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [jsc_pkg::INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]            cfg_wdata,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [jsc_pkg::LOOP_W-1:0]  loop_time,
    input  logic                        jump_request,
    input  logic signed [jsc_pkg::ACCEL_W-1:0] accel_z,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        servo_write,
    output logic [POS_BITS-1:0]         left_position,
    output logic [POS_BITS-1:0]         right_position,
    output logic [jsc_pkg::SPEED_W-1:0] move_speed,
    output logic [jsc_pkg::MACC_W-1:0]  move_accel,
    output logic [jsc_pkg::PHASE_W-1:0] phase,
    output logic                        jump_active
);
    import jsc_pkg::*;

    logic [POS_BITS-1:0] left_min_pos, left_max_pos, right_min_pos, right_max_pos;
    limits_t             limits;

    logic                       in_valid_reg;
    logic [LOOP_W-1:0]          loop_reg;
    logic                       request_reg;
    logic signed [ACCEL_W-1:0]  accel_reg;

    logic                       out_valid_reg;
    logic                       servo_write_reg;
    logic [POS_BITS-1:0]        left_reg, right_reg;
    logic [SPEED_W-1:0]         speed_reg;
    logic [MACC_W-1:0]          maccel_reg;
    logic [PHASE_W-1:0]         phase_out_reg;
    logic                       active_reg;

    logic                       servo_write_next;
    logic [POS_BITS-1:0]        left_next, right_next;
    logic [SPEED_W-1:0]         speed_next;
    logic [MACC_W-1:0]          maccel_next;
    logic [PHASE_W-1:0]         phase_out_next;
    logic                       active_next;

    logic advance;
    logic step;

    // output register free or emptying this cycle
    assign advance  = !out_valid_reg || out_ready;
    assign step     = in_valid_reg && advance;
    assign in_ready = !in_valid_reg || advance;

    jsc_cfg_regs #(
        .POS_BITS (POS_BITS),
        .CFG_W    (CFG_W)
    ) u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .left_min_pos  (left_min_pos),
        .left_max_pos  (left_max_pos),
        .right_min_pos (right_min_pos),
        .right_max_pos (right_max_pos),
        .limits        (limits)
    );

    jsc_sequencer #(
        .POS_BITS      (POS_BITS),
        .LANDING_ACCEL (LANDING_ACCEL)
    ) u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (step),
        .loop_time      (loop_reg),
        .jump_request   (request_reg),
        .accel_z        (accel_reg),
        .left_min_pos   (left_min_pos),
        .left_max_pos   (left_max_pos),
        .right_min_pos  (right_min_pos),
        .right_max_pos  (right_max_pos),
        .limits         (limits),
        .servo_write    (servo_write_next),
        .left_position  (left_next),
        .right_position (right_next),
        .move_speed     (speed_next),
        .move_accel     (maccel_next),
        .phase          (phase_out_next),
        .jump_active    (active_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            loop_reg    <= loop_time;
            request_reg <= jump_request;
            accel_reg   <= accel_z;
        end
        if (step)
        begin
            servo_write_reg <= servo_write_next;
            left_reg        <= left_next;
            right_reg       <= right_next;
            speed_reg       <= speed_next;
            maccel_reg      <= maccel_next;
            phase_out_reg   <= phase_out_next;
            active_reg      <= active_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign servo_write    = servo_write_reg;
    assign left_position  = left_reg;
    assign right_position = right_reg;
    assign move_speed     = speed_reg;
    assign move_accel     = maccel_reg;
    assign phase          = phase_out_reg;
    assign jump_active    = active_reg;

endmodule
